FILE: rtl/core/trsc_pkg.sv
// package for the torque request sanity check
// register indexes, field widths, stage types and the divider step; no dependencies
package trsc_pkg;

  // field widths
  localparam int unsigned TorqueW = 8;
  localparam int unsigned RpmW    = 16;
  localparam int unsigned WordW   = 16;
  localparam int unsigned TempW   = 8;
  localparam int unsigned CurrW   = 15;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;
  // product of a non-negative torque and the limit
  localparam int unsigned ProdW   = 15;
  // quotient bits; the scaled torque is always below 128
  localparam int unsigned QuotW   = 7;
  // quotient bits resolved in the first divider stage
  localparam int unsigned QuotHiW = 4;
  localparam int unsigned QuotLoW = QuotW - QuotHiW;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_REGEN_ENABLE     = 3'd0,
    CFG_MAX_CELL_VOLTAGE = 3'd1,
    CFG_MAX_CELL_TEMP    = 3'd2,
    CFG_MAX_REGEN_CURR   = 3'd3,
    CFG_MIN_REGEN_RPM    = 3'd4,
    CFG_MIN_REGEN_SPEED  = 3'd5
  } cfg_idx_e;

  // first stage: checked torques and scaling decision
  typedef struct packed {
    logic signed [TorqueW-1:0] left;
    logic signed [TorqueW-1:0] right;
    logic [TorqueW-1:0]        limit;
    logic [TorqueW-1:0]        total;
    logic                      scale;
  } chk_t;

  // second stage: products for the two wheels
  typedef struct packed {
    logic signed [TorqueW-1:0] left;
    logic signed [TorqueW-1:0] right;
    logic [TorqueW-1:0]        total;
    logic                      scale;
    logic [ProdW-1:0]          prod_l;
    logic [ProdW-1:0]          prod_r;
  } prod_t;

  // third stage: partial quotients and remainders
  typedef struct packed {
    logic signed [TorqueW-1:0] left;
    logic signed [TorqueW-1:0] right;
    logic [TorqueW-1:0]        total;
    logic                      scale;
    logic [TorqueW-1:0]        rem_l;
    logic [TorqueW-1:0]        rem_r;
    logic [QuotHiW-1:0]        quo_l;
    logic [QuotHiW-1:0]        quo_r;
    logic [QuotLoW-1:0]        low_l;
    logic [QuotLoW-1:0]        low_r;
  } div_t;

  // one restoring division step: returns {quotient bit, new remainder}
  function automatic logic [TorqueW:0] div_step(input logic [TorqueW-1:0] rem,
                                                input logic               din,
                                                input logic [TorqueW-1:0] dvs);
    logic [TorqueW:0] sh;
    logic [TorqueW:0] diff;
    sh   = {rem, din};
    diff = sh - {1'b0, dvs};
    if (sh >= {1'b0, dvs}) begin
      div_step = {1'b1, diff[TorqueW-1:0]};
    end else begin
      div_step = {1'b0, sh[TorqueW-1:0]};
    end
  endfunction

endpackage

FILE: rtl/core/torque_request_sanity_check.sv
// torque request sanity check: regen gating, thresholds and limit scaling
// depends on trsc_pkg
// four register stages, the first loaded at the edge that accepts an item
// throughput: one item per cycle; the limit division is split over two divider stages
// a held stall on the output fills the stages and then stalls the input side
// reset clears the stage valid bits and sets all configuration registers to zero
module torque_request_sanity_check (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write channel
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [trsc_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [trsc_pkg::CfgDataW-1:0]        cfg_data_i,
  // input item channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [trsc_pkg::TorqueW-1:0]  left_request_i,
  input  logic signed [trsc_pkg::TorqueW-1:0]  right_request_i,
  input  logic [trsc_pkg::TorqueW-1:0]         torque_limit_i,
  input  logic signed [trsc_pkg::RpmW-1:0]     left_rpm_i,
  input  logic signed [trsc_pkg::RpmW-1:0]     right_rpm_i,
  input  logic [trsc_pkg::WordW-1:0]           vehicle_speed_i,
  input  logic [trsc_pkg::WordW-1:0]           min_cell_voltage_i,
  input  logic signed [trsc_pkg::TempW-1:0]    max_cell_temp_i,
  input  logic signed [trsc_pkg::WordW-1:0]    pack_current_i,
  // result item channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [trsc_pkg::TorqueW-1:0]  left_torque_o,
  output logic signed [trsc_pkg::TorqueW-1:0]  right_torque_o
);

  localparam int unsigned TW = trsc_pkg::TorqueW;

  // configuration registers
  logic                                regen_en_q;
  logic [trsc_pkg::WordW-1:0]          max_volt_q;
  logic signed [trsc_pkg::TempW-1:0]   max_temp_q;
  logic [trsc_pkg::CurrW-1:0]          max_curr_q;
  logic signed [trsc_pkg::RpmW-1:0]    min_rpm_q;
  logic [trsc_pkg::WordW-1:0]          min_speed_q;

  // stage valid bits and payloads
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;
  trsc_pkg::chk_t  s1_d, s1_q;
  trsc_pkg::prod_t s2_d, s2_q;
  trsc_pkg::div_t  s3_d, s3_q;
  logic signed [TW-1:0] left_d, right_d, left_q, right_q;

  // stage-one working signals
  logic                  allowed;
  logic signed [trsc_pkg::WordW:0] curr_ext;
  logic signed [trsc_pkg::WordW:0] curr_lim;
  logic signed [TW-1:0]  left_c, right_c;
  logic                  neg;
  logic [TW-1:0]         total;

  // configuration writes are always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regen_en_q  <= 1'b0;
      max_volt_q  <= '0;
      max_temp_q  <= '0;
      max_curr_q  <= '0;
      min_rpm_q   <= '0;
      min_speed_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (trsc_pkg::cfg_idx_e'(cfg_index_i))
        trsc_pkg::CFG_REGEN_ENABLE:     regen_en_q  <= cfg_data_i[0];
        trsc_pkg::CFG_MAX_CELL_VOLTAGE: max_volt_q  <= cfg_data_i;
        trsc_pkg::CFG_MAX_CELL_TEMP:    max_temp_q  <= cfg_data_i[trsc_pkg::TempW-1:0];
        trsc_pkg::CFG_MAX_REGEN_CURR:   max_curr_q  <= cfg_data_i[trsc_pkg::CurrW-1:0];
        trsc_pkg::CFG_MIN_REGEN_RPM:    min_rpm_q   <= cfg_data_i;
        trsc_pkg::CFG_MIN_REGEN_SPEED:  min_speed_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage flow control: a stage takes a new item when empty or when it moves on
  assign rdy4       = !v4_q || !out_stall_i;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_stall_o = !rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // stage one: regen permission, clamping, regen thresholds and limit check
  assign curr_ext = {pack_current_i[trsc_pkg::WordW-1], pack_current_i};
  assign curr_lim = -$signed({2'b00, max_curr_q});
  assign allowed  = regen_en_q && (min_cell_voltage_i < max_volt_q)
                    && (max_cell_temp_i < max_temp_q) && (curr_ext > curr_lim);
  assign left_c   = (!allowed && left_request_i[TW-1])  ? '0 : left_request_i;
  assign right_c  = (!allowed && right_request_i[TW-1]) ? '0 : right_request_i;
  assign neg      = left_c[TW-1] || right_c[TW-1];
  assign total    = {1'b0, left_c[TW-2:0]} + {1'b0, right_c[TW-2:0]};

  always_comb begin
    s1_d.limit = torque_limit_i;
    s1_d.total = total;
    if (neg) begin
      s1_d.scale = 1'b0;
      s1_d.left  = ((left_rpm_i < min_rpm_q) || (vehicle_speed_i < min_speed_q))
                   ? '0 : left_c;
      s1_d.right = ((right_rpm_i < min_rpm_q) || (vehicle_speed_i < min_speed_q))
                   ? '0 : right_c;
    end else begin
      s1_d.scale = total > torque_limit_i;
      s1_d.left  = left_c;
      s1_d.right = right_c;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) s1_q <= s1_d;
  end

  // stage two: torque times limit for each wheel
  always_comb begin
    s2_d.left   = s1_q.left;
    s2_d.right  = s1_q.right;
    s2_d.total  = s1_q.total;
    s2_d.scale  = s1_q.scale;
    s2_d.prod_l = {{(trsc_pkg::ProdW-TW+1){1'b0}}, s1_q.left[TW-2:0]}
                  * {{(trsc_pkg::ProdW-TW){1'b0}}, s1_q.limit};
    s2_d.prod_r = {{(trsc_pkg::ProdW-TW+1){1'b0}}, s1_q.right[TW-2:0]}
                  * {{(trsc_pkg::ProdW-TW){1'b0}}, s1_q.limit};
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) s2_q <= s2_d;
  end

  // stage three: upper quotient bits; the top product bits already sit below the total
  always_comb begin
    logic [TW:0] st_l;
    logic [TW:0] st_r;
    s3_d.left  = s2_q.left;
    s3_d.right = s2_q.right;
    s3_d.total = s2_q.total;
    s3_d.scale = s2_q.scale;
    s3_d.rem_l = s2_q.prod_l[trsc_pkg::ProdW-1:trsc_pkg::QuotW];
    s3_d.rem_r = s2_q.prod_r[trsc_pkg::ProdW-1:trsc_pkg::QuotW];
    s3_d.quo_l = '0;
    s3_d.quo_r = '0;
    s3_d.low_l = s2_q.prod_l[trsc_pkg::QuotLoW-1:0];
    s3_d.low_r = s2_q.prod_r[trsc_pkg::QuotLoW-1:0];
    for (int i = trsc_pkg::QuotW - 1; i >= trsc_pkg::QuotLoW; i--) begin
      st_l = trsc_pkg::div_step(s3_d.rem_l, s2_q.prod_l[i], s2_q.total);
      st_r = trsc_pkg::div_step(s3_d.rem_r, s2_q.prod_r[i], s2_q.total);
      s3_d.rem_l = st_l[TW-1:0];
      s3_d.rem_r = st_r[TW-1:0];
      s3_d.quo_l = {s3_d.quo_l[trsc_pkg::QuotHiW-2:0], st_l[TW]};
      s3_d.quo_r = {s3_d.quo_r[trsc_pkg::QuotHiW-2:0], st_r[TW]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) s3_q <= s3_d;
  end

  // stage four: lower quotient bits and the final choice of torques
  always_comb begin
    logic [TW-1:0]              rem_l;
    logic [TW-1:0]              rem_r;
    logic [trsc_pkg::QuotW-1:0] quo_l;
    logic [trsc_pkg::QuotW-1:0] quo_r;
    logic [TW:0]                st_l;
    logic [TW:0]                st_r;
    rem_l = s3_q.rem_l;
    rem_r = s3_q.rem_r;
    quo_l = {s3_q.quo_l, {trsc_pkg::QuotLoW{1'b0}}};
    quo_r = {s3_q.quo_r, {trsc_pkg::QuotLoW{1'b0}}};
    for (int i = trsc_pkg::QuotLoW - 1; i >= 0; i--) begin
      st_l     = trsc_pkg::div_step(rem_l, s3_q.low_l[i], s3_q.total);
      st_r     = trsc_pkg::div_step(rem_r, s3_q.low_r[i], s3_q.total);
      rem_l    = st_l[TW-1:0];
      rem_r    = st_r[TW-1:0];
      quo_l[i] = st_l[TW];
      quo_r[i] = st_r[TW];
    end
    left_d  = s3_q.scale ? $signed({1'b0, quo_l}) : s3_q.left;
    right_d = s3_q.scale ? $signed({1'b0, quo_r}) : s3_q.right;
  end

  always_ff @(posedge clk_i) begin
    if (rdy4 && v3_q) begin
      left_q  <= left_d;
      right_q <= right_d;
    end
  end

  // result item
  assign out_valid_o    = v4_q;
  assign left_torque_o  = left_q;
  assign right_torque_o = right_q;

endmodule

FILE: rtl/core/trsc_checker.sv
// port checks for the torque request sanity check, bound to the top level
// depends on trsc_pkg and torque_request_sanity_check
module trsc_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic signed [trsc_pkg::TorqueW-1:0] left_torque_o,
  input logic signed [trsc_pkg::TorqueW-1:0] right_torque_o
);

  // a stalled result item stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  // a stalled result item keeps its torques
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(left_torque_o) && $stable(right_torque_o))
    else $error("result torques changed while stalled");

  // the input side only stalls when a full pipeline meets a stalled output
  a_in_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // an accepted item reaches the output when the result side does not stall in between
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i
    |=> out_valid_o)
    else $error("accepted item did not reach the output in time");

endmodule

bind torque_request_sanity_check trsc_checker u_trsc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .left_torque_o  (left_torque_o),
  .right_torque_o (right_torque_o)
);

FILE: test/trsc_result_checker.sv
// checker for the torque request sanity check: watches the configuration, input and result
// channels, predicts the safe wheel torques of each item and compares them in order
// depends on trsc_pkg
module trsc_result_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write channel
  input  logic                                 cfg_valid_i,
  input  logic                                 cfg_ready_i,
  input  logic [trsc_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [trsc_pkg::CfgDataW-1:0]        cfg_data_i,
  // input item channel
  input  logic                                 in_valid_i,
  input  logic                                 in_stall_i,
  input  logic signed [trsc_pkg::TorqueW-1:0]  left_request_i,
  input  logic signed [trsc_pkg::TorqueW-1:0]  right_request_i,
  input  logic [trsc_pkg::TorqueW-1:0]         torque_limit_i,
  input  logic signed [trsc_pkg::RpmW-1:0]     left_rpm_i,
  input  logic signed [trsc_pkg::RpmW-1:0]     right_rpm_i,
  input  logic [trsc_pkg::WordW-1:0]           vehicle_speed_i,
  input  logic [trsc_pkg::WordW-1:0]           min_cell_voltage_i,
  input  logic signed [trsc_pkg::TempW-1:0]    max_cell_temp_i,
  input  logic signed [trsc_pkg::WordW-1:0]    pack_current_i,
  // result item channel
  input  logic                                 out_valid_i,
  input  logic                                 out_stall_i,
  input  logic signed [trsc_pkg::TorqueW-1:0]  left_torque_i,
  input  logic signed [trsc_pkg::TorqueW-1:0]  right_torque_i,
  // status towards the testbench top
  output int                                   mismatch_count_o,
  output int                                   pending_o
);
  import trsc_pkg::*;

  typedef struct packed {
    logic signed [TorqueW-1:0] left;
    logic signed [TorqueW-1:0] right;
  } torque_pair_t;

  // own copy of the configuration registers
  logic                      regen_en;
  logic [WordW-1:0]          max_mv;
  logic signed [TempW-1:0]   max_temp;
  logic [CurrW-1:0]          max_curr;
  logic signed [RpmW-1:0]    min_rpm;
  logic [WordW-1:0]          min_speed;

  // torques still to come out of the block, oldest first
  torque_pair_t pending_torques[$];

  // safe wheel torques for one item under the current configuration
  function automatic torque_pair_t checked_torques(
    input logic signed [TorqueW-1:0] left_req,
    input logic signed [TorqueW-1:0] right_req,
    input logic [TorqueW-1:0]        limit_nm,
    input logic signed [RpmW-1:0]    left_rpm,
    input logic signed [RpmW-1:0]    right_rpm,
    input logic [WordW-1:0]          speed,
    input logic [WordW-1:0]          cell_mv,
    input logic signed [TempW-1:0]   cell_temp,
    input logic signed [WordW-1:0]   current
  );
    int           left;
    int           right;
    int           lim;
    int           total;
    int           curr;
    int           curr_floor;
    logic         regen_ok;
    torque_pair_t res;
    left       = left_req;
    right      = right_req;
    lim        = limit_nm;
    curr       = current;
    curr_floor = max_curr;
    curr_floor = -curr_floor;
    regen_ok   = regen_en && (cell_mv < max_mv) && (cell_temp < max_temp) &&
                 (curr > curr_floor);
    // negative torque only while the pack can take regen
    if (!regen_ok) begin
      if (left < 0) left = 0;
      if (right < 0) right = 0;
    end
    if (left < 0 || right < 0) begin
      // regen thresholds, and no limit scaling
      if (left_rpm < min_rpm) left = 0;
      if (right_rpm < min_rpm) right = 0;
      if (speed < min_speed) begin
        left  = 0;
        right = 0;
      end
    end else begin
      // scale both wheels down to the total limit
      total = left + right;
      if (total > lim && total != 0) begin
        left  = (left * lim) / total;
        right = (right * lim) / total;
      end
    end
    res.left  = left[TorqueW-1:0];
    res.right = right[TorqueW-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    torque_pair_t got;
    torque_pair_t want;
    if (!rst_ni) begin
      regen_en         = 1'b0;
      max_mv           = '0;
      max_temp         = '0;
      max_curr         = '0;
      min_rpm          = '0;
      min_speed        = '0;
      mismatch_count_o = 0;
      pending_o        = 0;
    end else begin
      // register writes; spare indexes change nothing
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_REGEN_ENABLE:     regen_en  = cfg_data_i[0];
          CFG_MAX_CELL_VOLTAGE: max_mv    = cfg_data_i;
          CFG_MAX_CELL_TEMP:    max_temp  = cfg_data_i[TempW-1:0];
          CFG_MAX_REGEN_CURR:   max_curr  = cfg_data_i[CurrW-1:0];
          CFG_MIN_REGEN_RPM:    min_rpm   = cfg_data_i;
          CFG_MIN_REGEN_SPEED:  min_speed = cfg_data_i;
          default: ;
        endcase
      end
      // result items against the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        got.left  = left_torque_i;
        got.right = right_torque_i;
        if (pending_torques.size() == 0) begin
          $error("result item with none outstanding: left_torque %0d, right_torque %0d",
                 got.left, got.right);
          mismatch_count_o++;
        end else begin
          want = pending_torques.pop_front();
          if (got.left !== want.left) begin
            $error("left_torque: expected %0d, got %0d", want.left, got.left);
            mismatch_count_o++;
          end
          if (got.right !== want.right) begin
            $error("right_torque: expected %0d, got %0d", want.right, got.right);
            mismatch_count_o++;
          end
        end
      end
      // accepted input items
      if (in_valid_i && !in_stall_i) begin
        pending_torques.push_back(checked_torques(left_request_i, right_request_i,
                                                  torque_limit_i, left_rpm_i, right_rpm_i,
                                                  vehicle_speed_i, min_cell_voltage_i,
                                                  max_cell_temp_i, pack_current_i));
      end
      pending_o = pending_torques.size();
    end
  end

endmodule

FILE: test/tb_torque_request_sanity_check.sv
// testbench top for the torque request sanity check: clock, reset, configuration phases,
// directed and random items with bursty sending and patterned result stalls
// depends on trsc_pkg, torque_request_sanity_check and trsc_result_checker
module tb_torque_request_sanity_check;
  import trsc_pkg::*;

  // register indexes past the end of the list
  localparam logic [CfgIdxW-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_HI = 3'd7;

  typedef struct {
    logic signed [TorqueW-1:0] lreq;
    logic signed [TorqueW-1:0] rreq;
    logic [TorqueW-1:0]        limit;
    logic signed [RpmW-1:0]    lrpm;
    logic signed [RpmW-1:0]    rrpm;
    logic [WordW-1:0]          speed;
    logic [WordW-1:0]          cellv;
    logic signed [TempW-1:0]   temp;
    logic signed [WordW-1:0]   curr;
  } torque_tick_t;

  logic                      clk_i = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CfgIdxW-1:0]        cfg_index = '0;
  logic [CfgDataW-1:0]       cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic signed [TorqueW-1:0] left_request = '0;
  logic signed [TorqueW-1:0] right_request = '0;
  logic [TorqueW-1:0]        torque_limit = '0;
  logic signed [RpmW-1:0]    left_rpm = '0;
  logic signed [RpmW-1:0]    right_rpm = '0;
  logic [WordW-1:0]          vehicle_speed = '0;
  logic [WordW-1:0]          min_cell_voltage = '0;
  logic signed [TempW-1:0]   max_cell_temp = '0;
  logic signed [WordW-1:0]   pack_current = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [TorqueW-1:0] left_torque;
  logic signed [TorqueW-1:0] right_torque;
  int                        mismatch_count;
  int                        pending;

  // thresholds of the current setting, used to aim the telemetry
  int mv_lim;
  int temp_lim;
  int curr_lim;
  int rpm_lim;
  int speed_lim;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  torque_request_sanity_check dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_n),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .left_request_i     (left_request),
    .right_request_i    (right_request),
    .torque_limit_i     (torque_limit),
    .left_rpm_i         (left_rpm),
    .right_rpm_i        (right_rpm),
    .vehicle_speed_i    (vehicle_speed),
    .min_cell_voltage_i (min_cell_voltage),
    .max_cell_temp_i    (max_cell_temp),
    .pack_current_i     (pack_current),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .left_torque_o      (left_torque),
    .right_torque_o     (right_torque)
  );

  trsc_result_checker u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_n),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_i        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_stall_i         (in_stall),
    .left_request_i     (left_request),
    .right_request_i    (right_request),
    .torque_limit_i     (torque_limit),
    .left_rpm_i         (left_rpm),
    .right_rpm_i        (right_rpm),
    .vehicle_speed_i    (vehicle_speed),
    .min_cell_voltage_i (min_cell_voltage),
    .max_cell_temp_i    (max_cell_temp),
    .pack_current_i     (pack_current),
    .out_valid_i        (out_valid),
    .out_stall_i        (out_stall),
    .left_torque_i      (left_torque),
    .right_torque_i     (right_torque),
    .mismatch_count_o   (mismatch_count),
    .pending_o          (pending)
  );

  // value within spread of centre, clipped to the field range
  function automatic int nudge(input int centre, input int spread, input int lo, input int hi);
    int v;
    v = centre + $urandom_range(0, 2 * spread) - spread;
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v;
  endfunction

  function automatic torque_tick_t compose_tick(input int l, input int r, input int lim,
                                                input int lrpm, input int rrpm, input int spd,
                                                input int mv, input int tmp, input int cur);
    torque_tick_t t;
    t.lreq  = 8'(l);
    t.rreq  = 8'(r);
    t.limit = 8'(lim);
    t.lrpm  = 16'(lrpm);
    t.rrpm  = 16'(rrpm);
    t.speed = 16'(spd);
    t.cellv = 16'(mv);
    t.temp  = 8'(tmp);
    t.curr  = 16'(cur);
    return t;
  endfunction

  // mostly telemetry close to the regen thresholds, the rest anywhere
  function automatic torque_tick_t random_tick();
    torque_tick_t t;
    t = compose_tick($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                     $urandom(), $urandom(), $urandom());
    if ($urandom_range(0, 3) == 0) begin
      t.limit = 8'($urandom_range(0, 40));
    end
    if ($urandom_range(0, 9) < 7) begin
      t.lrpm  = 16'(nudge(rpm_lim + 100, 150, -32768, 32767));
      t.rrpm  = 16'(nudge(rpm_lim + 100, 150, -32768, 32767));
      t.speed = 16'(nudge(speed_lim + 30, 40, 0, 65535));
      t.cellv = 16'(nudge(mv_lim - 40, 60, 0, 65535));
      t.temp  = 8'(nudge(temp_lim - 5, 8, -128, 127));
      t.curr  = 16'(nudge(60 - curr_lim, 80, -32768, 32767));
    end
    return t;
  endfunction

  // one register write; the caller lowers cfg_valid after its last write
  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  task automatic apply_settings(input logic [15:0] regen, input logic [15:0] mv,
                                input logic [15:0] tmp, input logic [15:0] cur,
                                input logic [15:0] rpm, input logic [15:0] spd);
    write_register(CFG_REGEN_ENABLE, regen);
    write_register(CFG_MAX_CELL_VOLTAGE, mv);
    write_register(CFG_MAX_CELL_TEMP, tmp);
    write_register(CFG_MAX_REGEN_CURR, cur);
    write_register(CFG_MIN_REGEN_RPM, rpm);
    write_register(CFG_MIN_REGEN_SPEED, spd);
    cfg_valid <= 1'b0;
    mv_lim    = mv;
    temp_lim  = $signed(tmp[7:0]);
    curr_lim  = cur[14:0];
    rpm_lim   = $signed(rpm);
    speed_lim = spd;
  endtask

  // offer one item and hold it until it is taken
  task automatic offer(input torque_tick_t t);
    in_valid         <= 1'b1;
    left_request     <= t.lreq;
    right_request    <= t.rreq;
    torque_limit     <= t.limit;
    left_rpm         <= t.lrpm;
    right_rpm        <= t.rrpm;
    vehicle_speed    <= t.speed;
    min_cell_voltage <= t.cellv;
    max_cell_temp    <= t.temp;
    pack_current     <= t.curr;
    do @(posedge clk_i); while (in_stall);
  endtask

  // random items in bursts with idle gaps between them
  task automatic run_random(input int count);
    int burst;
    int gap;
    int sent;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && sent < count) begin
        offer(random_tick());
        burst--;
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0 && sent < count) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid <= 1'b0;
  endtask

  // wait for every outstanding result, then let the stages settle
  task automatic drain();
    do @(negedge clk_i); while (pending != 0);
    repeat (6) @(posedge clk_i);
  endtask

  // result side stalls: quiet, random, heavy and toggling stretches, with a long hold-off
  initial begin : receiver
    int span;
    int style;
    int windows;
    windows = 0;
    forever begin
      windows++;
      if (windows % 9 == 4) begin
        // long hold-off so the stages fill and the input side stalls
        out_stall <= 1'b1;
        repeat (90) @(posedge clk_i);
      end else begin
        style = $urandom_range(0, 3);
        span  = $urandom_range(10, 120);
        repeat (span) begin
          case (style)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 1) == 1);
            2:       out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= ~out_stall;
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  initial begin
    #3_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    int phase;
    mv_lim    = 0;
    temp_lim  = 0;
    curr_lim  = 0;
    rpm_lim   = 0;
    speed_lim = 0;
    repeat (7) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // registers at their reset values: no regen at all
    run_random(250);
    drain();

    // typical pack limits, then the directed items
    apply_settings(16'd1, 16'd4150, 16'd45, 16'd200, 16'd100, 16'd5);
    // plain request, no scaling at the limit
    offer(compose_tick(127, 127, 255, 500, 500, 100, 4000, 30, 0));
    // scaled, zero limit, zero total
    offer(compose_tick(127, 127, 100, 500, 500, 100, 4000, 30, 0));
    offer(compose_tick(127, 1, 0, 500, 500, 100, 4000, 30, 0));
    offer(compose_tick(0, 0, 0, 500, 500, 100, 4000, 30, 0));
    offer(compose_tick(64, 64, 127, 500, 500, 100, 4000, 30, 0));
    // regen allowed: negative torques pass, the other wheel is not scaled
    offer(compose_tick(-128, -128, 255, 500, 500, 100, 4000, 30, 0));
    offer(compose_tick(-128, 127, 10, 500, 500, 100, 4000, 30, 0));
    offer(compose_tick(-1, 0, 0, 500, 500, 100, 4000, 30, 0));
    // per-wheel rpm threshold and vehicle speed threshold
    offer(compose_tick(-50, 20, 255, 99, 500, 100, 4000, 30, 0));
    offer(compose_tick(20, -50, 255, 500, 99, 100, 4000, 30, 0));
    offer(compose_tick(-50, -50, 255, 100, 100, 100, 4000, 30, 0));
    offer(compose_tick(-50, -50, 255, 500, 500, 4, 4000, 30, 0));
    offer(compose_tick(-50, -50, 255, 500, 500, 5, 4000, 30, 0));
    // regen refused by cell voltage, temperature and current: negatives clamp to zero; the last item is just allowed
    offer(compose_tick(-100, 120, 60, 500, 500, 100, 4150, 30, 0));
    offer(compose_tick(-100, 120, 60, 500, 500, 100, 4149, 45, 0));
    offer(compose_tick(-100, -20, 255, 500, 500, 100, 4000, 30, -200));
    offer(compose_tick(-100, -20, 255, 500, 500, 100, 4000, 44, -199));
    // just at and just over the limit
    offer(compose_tick(1, 127, 128, 500, 500, 100, 4000, 30, 0));
    offer(compose_tick(1, 127, 127, 500, 500, 100, 4000, 30, 0));
    // telemetry extremes
    offer(compose_tick(127, -128, 0, -32768, 32767, 65535, 0, -128, 32767));
    offer(compose_tick(-128, 127, 255, 32767, -32768, 0, 65535, 127, -32768));
    in_valid <= 1'b0;
    run_random(350);
    drain();

    // most permissive setting; high bits above each register's width are dropped
    apply_settings(16'hFFFF, 16'hFFFF, 16'hFF7F, 16'hFFFF, 16'h8000, 16'h0000);
    run_random(300);
    drain();

    // strictest setting: regen can never be granted
    apply_settings(16'd1, 16'h0000, 16'hFF80, 16'h0000, 16'h7FFF, 16'hFFFF);
    run_random(200);
    drain();

    // regen switched off by an even write, and writes to spare indexes are ignored
    apply_settings(16'hFFFE, 16'd4150, 16'd45, 16'd200, 16'd100, 16'd5);
    write_register(CFG_SPARE_LO, 16'hFFFF);
    write_register(CFG_SPARE_HI, 16'hFFFF);
    cfg_valid <= 1'b0;
    run_random(200);
    drain();

    // random settings
    for (phase = 0; phase < 2; phase++) begin
      apply_settings(16'($urandom_range(0, 3) != 0), 16'($urandom()), 16'($urandom()),
                     16'($urandom()), 16'($urandom()), 16'($urandom()));
      run_random(275);
      drain();
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    if (mismatch_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/trsc_pkg.sv
rtl/core/torque_request_sanity_check.sv
rtl/core/trsc_checker.sv
test/trsc_result_checker.sv
test/tb_torque_request_sanity_check.sv
